### design/compacting_value_list_unit_defines.svh
// Assertion macros for the compacting value list.
`ifndef COMPACTING_VALUE_LIST_UNIT_DEFINES_SVH
`define COMPACTING_VALUE_LIST_UNIT_DEFINES_SVH

`ifndef SYNTHESIS

// Property checked at every clock edge outside reset.
`define CVL_ASSERT(lbl, clk, rstn, prop) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) \
		else $error("cvl: assertion failed");

// Antecedent this cycle implies consequent in the next cycle.
`define CVL_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
		else $error("cvl: assertion failed");

`else

`define CVL_ASSERT(lbl, clk, rstn, prop)
`define CVL_ASSERT_NEXT(lbl, clk, rstn, ante, cons)

`endif

`endif

### design/cvl_pkg.sv
`default_nettype none

package cvl_pkg;

	localparam int VALUE_W = 32;
	localparam int POS_W   = 3;

	typedef enum logic [1:0] {
		CMD_INSERT = 2'd0,
		CMD_FIND   = 2'd1,
		CMD_DELETE = 2'd2
	} cvl_cmd_t;

	// Broadcast from the top level to every cell.
	typedef struct packed {
		logic               ins;
		logic               del;
		logic [VALUE_W-1:0] key;
		logic [VALUE_W-1:0] wdata;
	} cvl_op_t;

	// Handed from cell to cell: match seen so far and its position.
	typedef struct packed {
		logic             found;
		logic [POS_W-1:0] pos;
	} cvl_link_t;

endpackage

`default_nettype wire

### design/cvl_channels.sv
`default_nettype none

interface cvl_in_if;
	logic                                valid;
	logic                                ready;
	logic [1:0]                          cmd;
	logic signed [cvl_pkg::VALUE_W-1:0]  item_value;

	modport source (output valid, output cmd, output item_value, input ready);
	modport sink   (input valid, input cmd, input item_value, output ready);
endinterface

interface cvl_out_if;
	logic                        valid;
	logic                        ready;
	logic                        hit;
	logic [cvl_pkg::POS_W-1:0]   position;
	logic                        list_full;

	modport source (output valid, output hit, output position, output list_full, input ready);
	modport sink   (input valid, input hit, input position, input list_full, output ready);
endinterface

`default_nettype wire

### design/cvl_cell.sv
`default_nettype none

module cvl_cell #(
	parameter int CELL_IDX = 0
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  cvl_pkg::cvl_op_t              op,
	input  logic [cvl_pkg::VALUE_W-1:0]   up_data,
	input  cvl_pkg::cvl_link_t            link_in,
	output cvl_pkg::cvl_link_t            link_out,
	output logic [cvl_pkg::VALUE_W-1:0]   slot
);

	logic [cvl_pkg::VALUE_W-1:0] slot_q;
	logic                        is_match;
	logic                        first;

	assign is_match = (slot_q == op.key);
	assign first    = is_match && !link_in.found;

	assign link_out.found = link_in.found || is_match;
	assign link_out.pos   = first ? cvl_pkg::POS_W'(CELL_IDX) : link_in.pos;
	assign slot           = slot_q;

	// Delete: this cell and every later one take the upper neighbor's word.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			slot_q <= '0;
		end else begin
			if (op.ins && first) begin
				slot_q <= op.wdata;
			end else if (op.del && link_out.found) begin
				slot_q <= up_data;
			end
		end
	end

endmodule

`default_nettype wire

### design/compacting_value_list_unit.sv
// Channel  Dir  Payload                          Beat when
// in_ch    in   cmd[1:0], item_value[31:0] s     valid && ready
// out_ch   out  hit, position[2:0], list_full    valid && ready
//
// One beat per cycle unless out_ch stalls: every cell compares its slot with the key and the
// first-match flag ripples up the chain of SLOT_COUNT cells in the same cycle.
// The result appears in the output register in the cycle after the input beat.
// in_ch.ready is low only while a result is held and out_ch.ready is low.
// Reset empties every slot at once; no clearing pass.
`default_nettype none
`include "compacting_value_list_unit_defines.svh"

module compacting_value_list_unit #(
	parameter int SLOT_COUNT = 8
) (
	input  logic      clk,
	input  logic      arst_n,
	cvl_in_if.sink    in_ch,
	cvl_out_if.source out_ch
);

	cvl_pkg::cvl_op_t            op;
	cvl_pkg::cvl_link_t          link [SLOT_COUNT+1];
	logic [cvl_pkg::VALUE_W-1:0] slot_data [SLOT_COUNT+1];
	logic                        accept;
	logic                        is_ins;
	logic                        is_del;
	logic                        is_find;
	logic                        res_hit;
	logic                        res_full;

	logic                        out_valid_q;
	logic                        hit_q;
	logic [cvl_pkg::POS_W-1:0]   pos_q;
	logic                        full_q;

	assign in_ch.ready = !out_valid_q || out_ch.ready;
	assign accept      = in_ch.valid && in_ch.ready;

	always_comb begin
		is_ins  = 1'b0;
		is_del  = 1'b0;
		is_find = 1'b0;
		unique case (in_ch.cmd)
			cvl_pkg::CMD_INSERT: begin
				is_ins = 1'b1;
			end
			cvl_pkg::CMD_FIND: begin
				is_find = 1'b1;
			end
			cvl_pkg::CMD_DELETE: begin
				is_del = 1'b1;
			end
			default: begin
			end
		endcase
	end

	// Insert looks for the first empty slot, i.e. a zero word.
	assign op.ins   = accept && is_ins;
	assign op.del   = accept && is_del;
	assign op.key   = is_ins ? '0 : unsigned'(in_ch.item_value);
	assign op.wdata = unsigned'(in_ch.item_value);

	assign link[0]               = '0;
	assign slot_data[SLOT_COUNT] = '0;

	for (genvar g = 0; g < SLOT_COUNT; g++) begin : g_cell
		cvl_cell #(
			.CELL_IDX(g)
		) u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.op       (op),
			.up_data  (slot_data[g+1]),
			.link_in  (link[g]),
			.link_out (link[g+1]),
			.slot     (slot_data[g])
		);
	end

	assign res_hit  = (is_ins || is_find || is_del) && link[SLOT_COUNT].found;
	assign res_full = is_ins && !link[SLOT_COUNT].found;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (accept) begin
			out_valid_q <= 1'b1;
		end else if (out_ch.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			hit_q  <= res_hit;
			pos_q  <= res_hit ? link[SLOT_COUNT].pos : '0;
			full_q <= res_full;
		end
	end

	assign out_ch.valid     = out_valid_q;
	assign out_ch.hit       = hit_q;
	assign out_ch.position  = pos_q;
	assign out_ch.list_full = full_q;

	`CVL_ASSERT(a_hit_full_excl, clk, arst_n, !(out_ch.valid && out_ch.hit && out_ch.list_full))
	`CVL_ASSERT_NEXT(a_accept_result, clk, arst_n, accept, out_ch.valid)
	`CVL_ASSERT_NEXT(a_delete_top_empty, clk, arst_n, op.del && link[SLOT_COUNT].found, slot_data[SLOT_COUNT-1] == '0)

endmodule

`default_nettype wire
